// File: rtl/core/upd_pkg.sv
// Shared constants, types and the hex digit mapping of the URL percent decoder.
package upd_pkg;

   localparam logic [7:0]  PCT_CHAR  = 8'h25;
   localparam logic [15:0] LEN_RESET = 16'h4fff;
   localparam logic [15:0] CNT_MAX   = 16'hffff;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_MAX_LENGTH = 1'b0;

   typedef enum logic [1:0] {
      PH_TEXT = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       have;
   } emit_type;

   // Map one character to its hex digit value; other characters map to themselves.
   function automatic logic [7:0] digit_value(input logic [7:0] b);
      logic [7:0] v;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = b - 8'h30;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = b - 8'h37;
      end else if (b > 8'h60 && b < 8'h67) begin
         v = b + 8'ha9;
      end else begin
         v = b;
      end
      return v;
   endfunction

endpackage

// File: rtl/core/url_percent_decoder.sv
// Top level of the streaming URL percent decoder with its register port.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata: in_byte, tlast: is_last
//   rsp      out        rsp_tvalid/rsp_tready  tdata: out_byte, tlast: end_of_string,
//                                              tuser: data_valid, ok
//   csr      in         APB, pready always 1   max_length at byte addresses 0 to 3
//
// One word is accepted every cycle while the result side keeps up. A word lands in
// the input register when accepted, and its result, if it yields one, is loaded into
// the result register as the word leaves the input register, together with the decode
// state update. When the result register holds a word that is not taken, the pipeline
// stalls and req_tready falls once the input register is full too.
// Reset is synchronous and returns max_length to 0x4fff and the decoder to
// plain text with a zero count.
module url_percent_decoder
   import upd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] in_byte
   input  logic                  req_tlast,   // is_last

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast,   // end_of_string
   output logic [1:0]            rsp_tuser,   // [0] data_valid, [1] ok

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Configuration register.
   logic [15:0] max_length_ff, max_length_in;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Decoder state.
   phase_type   phase_ff, phase_in;
   logic [7:0]  high_part_ff, high_part_in;
   logic [15:0] char_count_ff, char_count_in;
   logic        terminated_ff, terminated_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_dv_ff, out_dv_in;
   logic        out_last_ff, out_last_in;
   logic        out_ok_ff, out_ok_in;

   logic        out_free;
   logic        advance;
   logic [15:0] count_next;
   logic [7:0]  digit;
   emit_type    raw_emit;
   logic        have;
   logic        csr_write;

   // The result register can take a new word when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      max_length_in = max_length_ff;
      if (csr_write && csr_paddr[CSR_ADDR_W-1] == REG_MAX_LENGTH) begin
         max_length_in = csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[CSR_ADDR_W-1] == REG_MAX_LENGTH) begin
         csr_prdata = {16'd0, max_length_ff};
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign digit      = digit_value(in_byte_ff);
   assign count_next = (char_count_ff == CNT_MAX) ? char_count_ff : char_count_ff + 16'd1;

   // Next phase and the high digit.
   always_comb begin
      phase_in     = phase_ff;
      high_part_in = high_part_ff;
      if (advance) begin
         case (phase_ff)
            PH_HIGH: begin
               high_part_in = digit;
               phase_in     = PH_LOW;
            end
            PH_LOW: begin
               phase_in = PH_TEXT;
            end
            default: begin
               if (in_byte_ff == PCT_CHAR) begin
                  phase_in = PH_HIGH;
               end
            end
         endcase
         if (in_last_ff) begin
            phase_in     = PH_TEXT;
            high_part_in = 8'd0;
         end
      end
   end

   // Byte that the current word would emit before termination is applied.
   always_comb begin
      raw_emit = '0;
      case (phase_ff)
         PH_HIGH: begin
            raw_emit.value = {digit[3:0], 4'd0};
            raw_emit.have  = in_last_ff;
         end
         PH_LOW: begin
            raw_emit.value = {high_part_ff[3:0], 4'd0} + digit;
            raw_emit.have  = 1'b1;
         end
         default: begin
            if (in_byte_ff != PCT_CHAR) begin
               raw_emit.value = in_byte_ff;
               raw_emit.have  = 1'b1;
            end
         end
      endcase
   end

   // A decoded zero ends the data part of the string; nothing is emitted after it.
   assign have = raw_emit.have && !terminated_ff && (raw_emit.value != 8'd0);

   always_comb begin
      terminated_in = terminated_ff;
      char_count_in = char_count_ff;
      if (advance) begin
         char_count_in = count_next;
         if (raw_emit.have && !have) begin
            terminated_in = 1'b1;
         end
         if (in_last_ff) begin
            char_count_in = 16'd0;
            terminated_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_dv_in    = out_dv_ff;
      out_last_in  = out_last_ff;
      out_ok_in    = out_ok_ff;
      if (out_free) begin
         out_valid_in = advance && (have || in_last_ff);
         out_byte_in  = have ? raw_emit.value : 8'd0;
         out_dv_in    = have;
         out_last_in  = in_last_ff;
         out_ok_in    = in_last_ff && (count_next <= max_length_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      out_byte_ff <= out_byte_in;
      out_dv_ff   <= out_dv_in;
      out_last_ff <= out_last_in;
      out_ok_ff   <= out_ok_in;
      if (reset) begin
         max_length_ff <= LEN_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_TEXT;
         high_part_ff  <= 8'd0;
         char_count_ff <= 16'd0;
         terminated_ff <= 1'b0;
      end else begin
         max_length_ff <= max_length_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         phase_ff      <= phase_in;
         high_part_ff  <= high_part_in;
         char_count_ff <= char_count_in;
         terminated_ff <= terminated_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_ok_ff, out_dv_ff};

endmodule
